// File: rtl/core/bod_pkg.sv
// Shared command codes, status codes and controller-to-datapath command struct.
package bod_pkg;

    localparam logic [2:0] CMD_INS_HEAD = 3'd0;
    localparam logic [2:0] CMD_INS_TAIL = 3'd1;
    localparam logic [2:0] CMD_INS_ORD  = 3'd2;
    localparam logic [2:0] CMD_RM_HEAD  = 3'd3;
    localparam logic [2:0] CMD_RM_TAIL  = 3'd4;
    localparam logic [2:0] CMD_RM_VAL   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
    } ctl_t;

endpackage

// File: rtl/core/bod_ctrl.sv
// Controller state machine sequencing capture, compare and update of each request.
module bod_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bod_pkg::ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;
    logic   upd_fire;
    logic   take_req;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign upd_fire  = (state_reg == S_UPD) && out_free;
    assign req_stall = !((state_reg == S_IDLE) || upd_fire);
    assign take_req  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;

    assign ctl.capture = take_req;
    assign ctl.compare = (state_reg == S_CMP);
    assign ctl.update  = upd_fire;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take_req)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_fire)
                begin
                    state_next = take_req ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (upd_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: rtl/core/bod_datapath.sv
// Row of entry cells with parallel compare, shift update and result registers.
module bod_datapath
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  bod_pkg::ctl_t      ctl,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] value,
    output logic [1:0]         status,
    output logic signed [31:0] removed_value,
    output logic [4:0]         entry_count,
    output logic signed [31:0] head_value
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [2:0]         cmd_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] cell_reg [CAPACITY];
    logic signed [31:0] cell_next [CAPACITY];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CAPACITY-1:0] hit_reg;
    logic [CAPACITY-1:0] hit_next;
    logic [CAPACITY-1:0] first_hit;
    logic [CAPACITY-1:0] at_or_after;
    logic signed [31:0] rm_word;
    logic               is_ins;
    logic               is_rm;
    logic               full;
    logic               empty;
    logic               found;
    logic               do_ins;
    logic               do_rm;
    logic [1:0]         status_next;
    logic [1:0]         status_reg;
    logic signed [31:0] removed_reg;
    logic [4:0]         entry_count_reg;
    logic signed [31:0] head_reg;

    always_comb
    begin
        logic in_use;
        logic at_count;
        logic at_last;
        for (int i = 0; i < CAPACITY; i++)
        begin
            in_use   = CW'(i) < count_reg;
            at_count = CW'(i) == count_reg;
            at_last  = CW'(i) == (count_reg - CW'(1));
            unique case (cmd_reg)
                bod_pkg::CMD_INS_HEAD: hit_next[i] = (i == 0);
                bod_pkg::CMD_INS_TAIL: hit_next[i] = at_count;
                bod_pkg::CMD_INS_ORD:
                    hit_next[i] = (in_use && (cell_reg[i] > value_reg)) || at_count;
                bod_pkg::CMD_RM_HEAD:  hit_next[i] = (i == 0);
                bod_pkg::CMD_RM_TAIL:  hit_next[i] = at_last;
                bod_pkg::CMD_RM_VAL:
                    hit_next[i] = in_use && (cell_reg[i] == value_reg);
                default:               hit_next[i] = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            first_hit[i]   = hit_reg[i] && !seen;
            seen           = seen || hit_reg[i];
            at_or_after[i] = seen;
        end
    end

    always_comb
    begin
        rm_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rm_word = rm_word | (first_hit[i] ? cell_reg[i] : 32'sd0);
        end
    end

    assign is_ins = (cmd_reg == bod_pkg::CMD_INS_HEAD) || (cmd_reg == bod_pkg::CMD_INS_TAIL)
                 || (cmd_reg == bod_pkg::CMD_INS_ORD);
    assign is_rm  = (cmd_reg == bod_pkg::CMD_RM_HEAD) || (cmd_reg == bod_pkg::CMD_RM_TAIL)
                 || (cmd_reg == bod_pkg::CMD_RM_VAL);
    assign full   = count_reg == CW'(CAPACITY);
    assign empty  = count_reg == '0;
    assign found  = |hit_reg;
    assign do_ins = is_ins && !full;
    assign do_rm  = is_rm && !empty && found;

    always_comb
    begin
        priority if (is_ins && full)
        begin
            status_next = bod_pkg::ST_FULL;
        end
        else if (is_rm && empty)
        begin
            status_next = bod_pkg::ST_EMPTY;
        end
        else if (is_rm && !found)
        begin
            status_next = bod_pkg::ST_NOTFOUND;
        end
        else
        begin
            status_next = bod_pkg::ST_OK;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        if (do_ins)
        begin
            if (at_or_after[0])
            begin
                cell_next[0] = value_reg;
            end
            for (int i = 1; i < CAPACITY; i++)
            begin
                if (at_or_after[i])
                begin
                    cell_next[i] = first_hit[i] ? value_reg : cell_reg[i-1];
                end
            end
        end
        else if (do_rm)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                if (at_or_after[i])
                begin
                    cell_next[i] = cell_reg[i+1];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rm)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
        end
        if (ctl.compare)
        begin
            hit_reg <= hit_next;
        end
        if (ctl.update)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
            status_reg      <= status_next;
            removed_reg     <= do_rm ? rm_word : 32'sd0;
            entry_count_reg <= 5'(count_next);
            head_reg        <= (count_next == '0) ? 32'sd0 : cell_next[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.update)
        begin
            count_reg <= count_next;
        end
    end

    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = entry_count_reg;
    assign head_value    = head_reg;

endmodule

// File: rtl/core/bounded_ordered_deque.sv
// Bounded ordered deque: a row of entry cells compared in parallel and shifted in one step.
// Each request is captured, compared in parallel into hit registers, then applied by the
// shift update, which waits while a stalled result is held; a new request is accepted as
// the previous one updates; a waiting result does not block the next request's compare.
// Reset clears the entry count and handshake state; entry cells are not cleared.
module bounded_ordered_deque
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic signed [31:0] removed_value,
    output logic [4:0]         entry_count,
    output logic signed [31:0] head_value
);

    bod_pkg::ctl_t ctl;

    bod_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    bod_datapath #(.CAPACITY(CAPACITY)) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .cmd           (cmd),
        .value         (value),
        .status        (status),
        .removed_value (removed_value),
        .entry_count   (entry_count),
        .head_value    (head_value)
    );

endmodule

// File: rtl/core/bod_checker.sv
// Port-level checker for the bounded ordered deque and its bind to the top level.
module bod_checker
#(
    parameter int CAPACITY = 16
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [1:0]         status,
    input logic signed [31:0] removed_value,
    input logic [4:0]         entry_count,
    input logic signed [31:0] head_value
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
            && $stable(removed_value) && $stable(entry_count) && $stable(head_value))
        else $error("stalled response changed or dropped");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |=> ##2 rsp_valid)
        else $error("response missing after request");

    a_no_removed_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != bod_pkg::ST_OK) |-> removed_value == 32'sd0)
        else $error("removed value nonzero on refused request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CAPACITY > 31) || (32'(entry_count) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (entry_count == 5'd0) |-> (CAPACITY > 31) || (head_value == 32'sd0))
        else $error("head value nonzero while empty");

endmodule

bind bounded_ordered_deque bod_checker #(.CAPACITY(CAPACITY)) u_bod_checker (.*);

// File: test/bounded_ordered_deque_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded ordered deque with a queue-fed driver and a monitor.
module bounded_ordered_deque_tb;

    localparam int DEPTH      = 16;
    localparam int CYCLE_CAP  = 300000;
    localparam int IDLE_PCT   = 26;
    localparam int DRAIN_WAIT = 10;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] word;
    } deque_request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed;
        logic [4:0]         count;
        logic signed [31:0] head;
    } deque_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [2:0]         cmd = bod_pkg::CMD_INS_HEAD;
    logic signed [31:0] value = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
    logic signed [31:0] head_value;

    deque_request_t     pending_requests[$];
    deque_result_t      expected_results[$];
    logic signed [31:0] held_words[$];

    logic req_fire = 1'b0;
    int   cycle_count = 0;
    int   accepted_requests = 0;
    int   checked_results = 0;
    int   mismatch_count = 0;
    int   full_refusals = 0;
    int   empty_removals = 0;
    int   missed_matches = 0;
    int   peak_count = 0;
    bit   calm;

    bounded_ordered_deque #(.CAPACITY(DEPTH)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .cmd           (cmd),
        .value         (value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .removed_value (removed_value),
        .entry_count   (entry_count),
        .head_value    (head_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign calm = (accepted_requests >= 500) && (accepted_requests < 700);

    task automatic apply_request(input logic [2:0] op, input logic signed [31:0] word);
        deque_result_t outcome;
        int            slot;
        outcome = '0;
        outcome.status = bod_pkg::ST_OK;
        if (op == bod_pkg::CMD_INS_HEAD || op == bod_pkg::CMD_INS_TAIL
            || op == bod_pkg::CMD_INS_ORD)
        begin
            if (held_words.size() >= DEPTH)
            begin
                outcome.status = bod_pkg::ST_FULL;
                full_refusals++;
            end
            else if (op == bod_pkg::CMD_INS_HEAD)
            begin
                held_words.push_front(word);
            end
            else if (op == bod_pkg::CMD_INS_TAIL)
            begin
                held_words.push_back(word);
            end
            else
            begin
                slot = held_words.size();
                for (int i = 0; i < held_words.size(); i++)
                begin
                    if (held_words[i] > word)
                    begin
                        slot = i;
                        break;
                    end
                end
                held_words.insert(slot, word);
            end
        end
        else if (op == bod_pkg::CMD_RM_HEAD || op == bod_pkg::CMD_RM_TAIL
                 || op == bod_pkg::CMD_RM_VAL)
        begin
            if (held_words.size() == 0)
            begin
                outcome.status = bod_pkg::ST_EMPTY;
                empty_removals++;
            end
            else if (op == bod_pkg::CMD_RM_HEAD)
            begin
                outcome.removed = held_words.pop_front();
            end
            else if (op == bod_pkg::CMD_RM_TAIL)
            begin
                outcome.removed = held_words.pop_back();
            end
            else
            begin
                slot = -1;
                for (int i = 0; i < held_words.size(); i++)
                begin
                    if (held_words[i] == word)
                    begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0)
                begin
                    outcome.status = bod_pkg::ST_NOTFOUND;
                    missed_matches++;
                end
                else
                begin
                    outcome.removed = held_words[slot];
                    held_words.delete(slot);
                end
            end
        end
        outcome.count = 5'(held_words.size());
        outcome.head  = (held_words.size() > 0) ? held_words[0] : '0;
        if (held_words.size() > peak_count)
        begin
            peak_count = held_words.size();
        end
        expected_results.push_back(outcome);
    endtask

    function automatic logic signed [31:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
        begin
            return $signed($urandom_range(7)) - 32'sd3;
        end
        else if (roll < 65)
        begin
            unique case ($urandom_range(3))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_request(input logic [2:0] op, input logic signed [31:0] word);
        deque_request_t item;
        item.op   = op;
        item.word = word;
        pending_requests.push_back(item);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
            if (req_fire || !req_valid)
            begin
                if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    req_valid <= 1'b1;
                    cmd       <= pending_requests[0].op;
                    value     <= pending_requests[0].word;
                    void'(pending_requests.pop_front());
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        deque_result_t want;
        cycle_count <= cycle_count + 1;
        req_fire    <= rst_n && req_valid && !req_stall;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                checked_results++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result with no request outstanding: status %0d count %0d",
                            status, entry_count);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status || removed_value !== want.removed ||
                        entry_count !== want.count || head_value !== want.head)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch: expected status %0d removed %0d count %0d head %0d",
                                want.status, want.removed, want.count, want.head);
                            $display("          actual   status %0d removed %0d count %0d head %0d",
                                status, removed_value, entry_count, head_value);
                        end
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                apply_request(cmd, value);
                accepted_requests++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL bounded_ordered_deque");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int burst;
        int insert_pct;
        int generated;

        queue_request(bod_pkg::CMD_RM_HEAD, 32'sd0);
        queue_request(bod_pkg::CMD_RM_TAIL, 32'sd0);
        queue_request(bod_pkg::CMD_RM_VAL, 32'sd5);
        queue_request(bod_pkg::CMD_INS_ORD, 32'sd0);
        queue_request(bod_pkg::CMD_RM_HEAD, 32'sd0);
        queue_request(bod_pkg::CMD_INS_HEAD, 32'sh7FFFFFFF);
        queue_request(bod_pkg::CMD_INS_TAIL, 32'sh80000000);
        queue_request(bod_pkg::CMD_INS_ORD, 32'sd0);
        queue_request(bod_pkg::CMD_INS_ORD, 32'sd0);
        queue_request(bod_pkg::CMD_INS_ORD, -32'sd1);
        queue_request(bod_pkg::CMD_INS_ORD, 32'sh7FFFFFFF);
        queue_request(bod_pkg::CMD_RM_VAL, 32'sd12345);
        queue_request(bod_pkg::CMD_RM_VAL, 32'sd0);
        queue_request(bod_pkg::CMD_RM_VAL, 32'sh80000000);
        queue_request(bod_pkg::CMD_RM_TAIL, 32'sd0);
        queue_request(bod_pkg::CMD_RM_HEAD, 32'sd0);
        queue_request(bod_pkg::CMD_RM_TAIL, 32'sd0);
        queue_request(bod_pkg::CMD_RM_TAIL, 32'sd0);
        queue_request(bod_pkg::CMD_RM_TAIL, 32'sd0);

        // Bursts that lean toward growth or shrinkage, or stay balanced, reach both the full and empty store.
        generated = 0;
        while (generated < 1200)
        begin
            mode  = $urandom_range(2);
            burst = $urandom_range(40, 24);
            insert_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(99) < insert_pct)
                begin
                    queue_request(3'(bod_pkg::CMD_INS_HEAD + $urandom_range(2)), pick_word());
                end
                else
                begin
                    queue_request(3'(bod_pkg::CMD_RM_HEAD + $urandom_range(2)), pick_word());
                end
            end
            generated += burst;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d requests accepted, %0d results checked, peak count %0d",
            accepted_requests, checked_results, peak_count);
        $display("%0d full refusals, %0d empty removals, %0d unmatched removals, %0d mismatches",
            full_refusals, empty_removals, missed_matches, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("PASS bounded_ordered_deque");
        end
        else
        begin
            $display("FAIL bounded_ordered_deque");
        end
        $finish;
    end

endmodule
